FILE: design/tfnl_pkg.sv
// ----------------------------------------------------------------------------
// tfnl_pkg
// Shared constants, types and codes of the tetrahedral face neighbor lookup.
// ----------------------------------------------------------------------------
package tfnl_pkg;

  // Table sizes and node id width.
  localparam int CellDepth  = 4096;
  localparam int FaceDepth  = 8192;
  localparam int NodeBits   = 16;
  localparam int CellAw     = $clog2(CellDepth);
  localparam int FaceAw     = $clog2(FaceDepth);
  localparam int CellCntW   = $clog2(CellDepth + 1);
  localparam int FaceCntW   = $clog2(FaceDepth + 1);
  localparam int CellW      = 13;
  localparam int KeyW       = 3 * NodeBits;
  localparam int FaceW      = KeyW + 2 * CellW;
  localparam int CellRowW   = 4 * NodeBits;

  // Request and result bus widths.
  localparam int InW  = 112;
  localparam int OutW = 16;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_APPEND_CELL = 3'd0,
    OP_APPEND_FACE = 3'd1,
    OP_CLEAR_FACES = 3'd2,
    OP_QUERY_FACE  = 3'd3,
    OP_QUERY_NBR   = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    RS_OK        = 3'd0,
    RS_BAD_CELL  = 3'd1,
    RS_BAD_FACE  = 3'd2,
    RS_NOT_FOUND = 3'd3,
    RS_FULL      = 3'd4
  } rstat_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CELL_RD,
    S_CELL_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DONE
  } state_t;

  // Datapath commands.
  typedef enum logic [3:0] {
    C_NONE,
    C_CAPTURE,
    C_APPEND_CELL,
    C_APPEND_FACE,
    C_CLEAR,
    C_SET_RESULT,
    C_SCAN_FROM_REQ,
    C_CELL_READ,
    C_SCAN_FROM_CELL,
    C_SCAN_READ,
    C_STEP,
    C_FOUND,
    C_EMIT
  } cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    rstat_t code;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       cell_full;
    logic       face_full;
    logic       cur_bad;
    logic       face_bad;
    logic       faces_zero;
    logic       match;
    logic       idx_zero;
    logic       out_free;
  } stat_t;

endpackage

FILE: design/tfnl_ram.sv
// ----------------------------------------------------------------------------
// tfnl_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module tfnl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a write cycle reads back the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/tfnl_ctrl.sv
// ----------------------------------------------------------------------------
// tfnl_ctrl
// Controller of the lookup engine: sequences decode, cell read and face scan.
// ----------------------------------------------------------------------------
module tfnl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  tfnl_pkg::stat_t st,
  output tfnl_pkg::ctrl_t ctl
);

  tfnl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfnl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tfnl_pkg::S_IDLE: begin
        if (s_tvalid) state_next = tfnl_pkg::S_DECODE;
      end
      tfnl_pkg::S_DECODE: begin
        state_next = tfnl_pkg::S_DONE;
        if (st.op == tfnl_pkg::OP_QUERY_FACE && !st.faces_zero) begin
          state_next = tfnl_pkg::S_SCAN_RD;
        end else if (st.op == tfnl_pkg::OP_QUERY_NBR && !st.cur_bad && !st.face_bad) begin
          state_next = tfnl_pkg::S_CELL_RD;
        end
      end
      tfnl_pkg::S_CELL_RD:   state_next = tfnl_pkg::S_CELL_WAIT;
      tfnl_pkg::S_CELL_WAIT: begin
        state_next = st.faces_zero ? tfnl_pkg::S_DONE : tfnl_pkg::S_SCAN_RD;
      end
      tfnl_pkg::S_SCAN_RD:   state_next = tfnl_pkg::S_SCAN_CMP;
      tfnl_pkg::S_SCAN_CMP: begin
        if (st.match || st.idx_zero) state_next = tfnl_pkg::S_DONE;
        else state_next = tfnl_pkg::S_SCAN_RD;
      end
      tfnl_pkg::S_DONE: begin
        if (st.out_free) state_next = tfnl_pkg::S_IDLE;
      end
      default: state_next = tfnl_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_tready = 1'b0;
    ctl.cmd  = tfnl_pkg::C_NONE;
    ctl.code = tfnl_pkg::RS_OK;
    case (state)
      tfnl_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) ctl.cmd = tfnl_pkg::C_CAPTURE;
      end
      tfnl_pkg::S_DECODE: begin
        ctl.cmd = tfnl_pkg::C_SET_RESULT;
        case (st.op)
          tfnl_pkg::OP_APPEND_CELL: begin
            if (st.cell_full) ctl.code = tfnl_pkg::RS_FULL;
            else ctl.cmd = tfnl_pkg::C_APPEND_CELL;
          end
          tfnl_pkg::OP_APPEND_FACE: begin
            if (st.face_full) ctl.code = tfnl_pkg::RS_FULL;
            else ctl.cmd = tfnl_pkg::C_APPEND_FACE;
          end
          tfnl_pkg::OP_CLEAR_FACES: ctl.cmd = tfnl_pkg::C_CLEAR;
          tfnl_pkg::OP_QUERY_FACE: begin
            if (st.faces_zero) ctl.code = tfnl_pkg::RS_NOT_FOUND;
            else ctl.cmd = tfnl_pkg::C_SCAN_FROM_REQ;
          end
          tfnl_pkg::OP_QUERY_NBR: begin
            if (st.cur_bad) ctl.code = tfnl_pkg::RS_BAD_CELL;
            else if (st.face_bad) ctl.code = tfnl_pkg::RS_BAD_FACE;
            else ctl.cmd = tfnl_pkg::C_CELL_READ;
          end
          default: ctl.code = tfnl_pkg::RS_OK;
        endcase
      end
      tfnl_pkg::S_CELL_RD: ctl.cmd = tfnl_pkg::C_CELL_READ;
      tfnl_pkg::S_CELL_WAIT: begin
        if (st.faces_zero) begin
          ctl.cmd  = tfnl_pkg::C_SET_RESULT;
          ctl.code = tfnl_pkg::RS_NOT_FOUND;
        end else begin
          ctl.cmd = tfnl_pkg::C_SCAN_FROM_CELL;
        end
      end
      tfnl_pkg::S_SCAN_RD: ctl.cmd = tfnl_pkg::C_SCAN_READ;
      tfnl_pkg::S_SCAN_CMP: begin
        if (st.match) begin
          ctl.cmd = tfnl_pkg::C_FOUND;
        end else if (st.idx_zero) begin
          ctl.cmd  = tfnl_pkg::C_SET_RESULT;
          ctl.code = tfnl_pkg::RS_NOT_FOUND;
        end else begin
          ctl.cmd = tfnl_pkg::C_STEP;
        end
      end
      tfnl_pkg::S_DONE: begin
        if (st.out_free) ctl.cmd = tfnl_pkg::C_EMIT;
      end
      default: ctl.cmd = tfnl_pkg::C_NONE;
    endcase
  end

endmodule

FILE: design/tfnl_dp.sv
// ----------------------------------------------------------------------------
// tfnl_dp
// Datapath of the lookup engine: request registers, cell and face tables,
// key sort, scan index and the result register.
// ----------------------------------------------------------------------------
module tfnl_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [tfnl_pkg::InW-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [tfnl_pkg::OutW-1:0] m_tdata,
  input  tfnl_pkg::ctrl_t          ctl,
  output tfnl_pkg::stat_t          st
);

  localparam int NB = tfnl_pkg::NodeBits;
  localparam int CW = tfnl_pkg::CellW;

  // Request registers.
  logic [2:0]      op;
  logic [NB-1:0]   na, nb, nc, nd;
  logic [CW-1:0]   adj0_in, adj1_in;
  logic [11:0]     cur;
  logic [2:0]      face;

  // Counters, key, scan index and result.
  logic [tfnl_pkg::CellCntW-1:0] cells_loaded;
  logic [tfnl_pkg::FaceCntW-1:0] faces_loaded;
  logic [tfnl_pkg::KeyW-1:0]     key;
  logic [tfnl_pkg::FaceAw-1:0]   scan_idx;
  logic [CW-1:0]                 res_cell;
  logic [2:0]                    res_stat;

  // Memory ports.
  logic                          cell_we, face_we;
  logic [tfnl_pkg::CellAw-1:0]   cell_addr;
  logic [tfnl_pkg::FaceAw-1:0]   face_addr;
  logic [tfnl_pkg::CellRowW-1:0] cell_rdata;
  logic [tfnl_pkg::FaceW-1:0]    face_wdata, face_rdata;

  logic [tfnl_pkg::KeyW-1:0] req_key, cell_key;
  logic [NB-1:0]             t0, t1, t2;
  logic [CW-1:0]             f_adj0, f_adj1, found_cell, cur_ext;

  function automatic logic [3*NB-1:0] sort3(input logic [NB-1:0] a, input logic [NB-1:0] b,
                                           input logic [NB-1:0] c);
    logic [NB-1:0] x, y, z, t;
    x = a;
    y = b;
    z = c;
    if (x > y) begin t = x; x = y; y = t; end
    if (y > z) begin t = y; y = z; z = t; end
    if (x > y) begin t = x; x = y; y = t; end
    return {z, y, x};
  endfunction

  // Sorted key of the request nodes.
  assign req_key = sort3(na, nb, nc);

  // Node triple of the chosen face of the cell read back.
  always_comb begin
    t0 = (face == 3'd3) ? cell_rdata[2*NB-1:NB] : cell_rdata[NB-1:0];
    t1 = (face <= 3'd1) ? cell_rdata[2*NB-1:NB] : cell_rdata[3*NB-1:2*NB];
    t2 = (face == 3'd0) ? cell_rdata[3*NB-1:2*NB] : cell_rdata[4*NB-1:3*NB];
  end
  assign cell_key = sort3(t0, t1, t2);

  // Adjacent cell selection for a matched face.
  assign f_adj0  = face_rdata[tfnl_pkg::KeyW +: CW];
  assign f_adj1  = face_rdata[tfnl_pkg::KeyW + CW +: CW];
  assign cur_ext = {1'b0, cur};
  always_comb begin
    if (op == tfnl_pkg::OP_QUERY_FACE) begin
      found_cell = (f_adj0 != '1) ? f_adj0 : f_adj1;
    end else if (f_adj0 != cur_ext) begin
      found_cell = f_adj0;
    end else if (f_adj1 != cur_ext) begin
      found_cell = f_adj1;
    end else begin
      found_cell = '1;
    end
  end

  // Memory port control.
  assign cell_we    = (ctl.cmd == tfnl_pkg::C_APPEND_CELL);
  assign face_we    = (ctl.cmd == tfnl_pkg::C_APPEND_FACE);
  assign cell_addr  = cell_we ? cells_loaded[tfnl_pkg::CellAw-1:0] : cur;
  assign face_addr  = face_we ? faces_loaded[tfnl_pkg::FaceAw-1:0] : scan_idx;
  assign face_wdata = {adj1_in, adj0_in, req_key};

  tfnl_ram #(.WIDTH(tfnl_pkg::CellRowW), .DEPTH(tfnl_pkg::CellDepth)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .addr  (cell_addr),
    .wdata ({nd, nc, nb, na}),
    .rdata (cell_rdata)
  );

  tfnl_ram #(.WIDTH(tfnl_pkg::FaceW), .DEPTH(tfnl_pkg::FaceDepth)) u_face_ram (
    .clk   (clk),
    .we    (face_we),
    .addr  (face_addr),
    .wdata (face_wdata),
    .rdata (face_rdata)
  );

  // Request capture.
  always_ff @(posedge clk) begin
    if (ctl.cmd == tfnl_pkg::C_CAPTURE) begin
      op      <= s_tdata[2:0];
      na      <= s_tdata[18:3];
      nb      <= s_tdata[34:19];
      nc      <= s_tdata[50:35];
      nd      <= s_tdata[66:51];
      adj0_in <= s_tdata[79:67];
      adj1_in <= s_tdata[92:80];
      cur     <= s_tdata[104:93];
      face    <= s_tdata[107:105];
    end
  end

  // Table fill counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_loaded <= '0;
      faces_loaded <= '0;
    end else begin
      if (ctl.cmd == tfnl_pkg::C_APPEND_CELL) cells_loaded <= cells_loaded + 1'b1;
      if (ctl.cmd == tfnl_pkg::C_APPEND_FACE) faces_loaded <= faces_loaded + 1'b1;
      if (ctl.cmd == tfnl_pkg::C_CLEAR) faces_loaded <= '0;
    end
  end

  // Search key, scan index from newest face down, and result.
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      tfnl_pkg::C_SCAN_FROM_REQ: begin
        key      <= req_key;
        scan_idx <= tfnl_pkg::FaceAw'(faces_loaded - 1'b1);
      end
      tfnl_pkg::C_SCAN_FROM_CELL: begin
        key      <= cell_key;
        scan_idx <= tfnl_pkg::FaceAw'(faces_loaded - 1'b1);
      end
      tfnl_pkg::C_STEP: scan_idx <= scan_idx - 1'b1;
      tfnl_pkg::C_APPEND_CELL: begin
        res_cell <= CW'(cells_loaded);
        res_stat <= tfnl_pkg::RS_OK;
      end
      tfnl_pkg::C_APPEND_FACE, tfnl_pkg::C_CLEAR: begin
        res_cell <= '1;
        res_stat <= tfnl_pkg::RS_OK;
      end
      tfnl_pkg::C_SET_RESULT: begin
        res_cell <= '1;
        res_stat <= ctl.code;
      end
      tfnl_pkg::C_FOUND: begin
        res_cell <= found_cell;
        res_stat <= tfnl_pkg::RS_OK;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.cmd == tfnl_pkg::C_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == tfnl_pkg::C_EMIT) m_tdata <= {res_stat, res_cell};
  end

  // Status toward the controller.
  always_comb begin
    st.op         = op;
    st.cell_full  = (cells_loaded >= tfnl_pkg::CellCntW'(tfnl_pkg::CellDepth));
    st.face_full  = (faces_loaded >= tfnl_pkg::FaceCntW'(tfnl_pkg::FaceDepth));
    st.cur_bad    = ({1'b0, cur} >= tfnl_pkg::CellCntW'(cells_loaded));
    st.face_bad   = (face > 3'd3);
    st.faces_zero = (faces_loaded == '0);
    st.match      = (face_rdata[tfnl_pkg::KeyW-1:0] == key);
    st.idx_zero   = (scan_idx == '0);
    st.out_free   = !m_tvalid || m_tready;
  end

endmodule

FILE: design/tet_face_neighbor_lookup.sv
// Flow: an append, a clear or a rejected request goes straight to its result. A face
// query scans the faces from the newest down; a neighbor query first reads the cell
// row. Each scan step reads the single face RAM port and then compares the key. One
// request is in work at a time; the next is accepted in the cycle after the result
// is loaded, later while it waits.
// Reset clears the cell and face counts; the tables keep stale contents.
// ----------------------------------------------------------------------------
// tet_face_neighbor_lookup
// Tetrahedral mesh adjacency engine with cell and face tables and queries.
// ----------------------------------------------------------------------------
module tet_face_neighbor_lookup (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // operation, node_a, node_b, node_c, node_d, first_adjacent,
  // second_adjacent, current_cell, exit_face, zero pad
  input  logic [tfnl_pkg::InW-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // result_cell, status
  output logic [tfnl_pkg::OutW-1:0] m_tdata
);

  tfnl_pkg::ctrl_t ctl;
  tfnl_pkg::stat_t st;

  tfnl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .ctl      (ctl)
  );

  tfnl_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .ctl      (ctl),
    .st       (st)
  );

endmodule
